/* design/itod_pkg.sv */
`default_nettype none
package itod_pkg;

  // operand width actually converted; bits of the input word above it are ignored
  localparam int VALUE_WIDTH = 64;
  // enough decimal digits for any value up to 64 bits
  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int BCD_W = 4;
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // binary bits shifted into the BCD register per cycle
  localparam int STEP_BITS = 4;
  localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W = STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef struct packed {
    logic load;   // capture input word, form magnitude, clear BCD
    logic step;   // STEP_BITS shift-add-3 iterations on magnitude and BCD
    logic count;  // latch index of the top nonzero digit
    logic emit;   // move current digit to output register, step index down
  } itod_cmd_t;

  typedef struct packed {
    logic idx_zero;  // current digit is the least significant one
  } itod_status_t;

endpackage
`default_nettype wire

/* design/itod_datapath.sv */
`default_nettype none
module itod_datapath
  import itod_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [63:0]        value_bits,
  input  wire logic               is_signed,
  input  wire itod_cmd_t          cmd,
  output itod_status_t            status,
  output logic [CHAR_W-1:0]       digit_char,
  output logic                    last_digit
);

  logic [VALUE_WIDTH-1:0] value_in;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag_in;

  logic [PAD_W-1:0]       mag;
  logic [BCD_W-1:0]       bcd [MAX_DIGITS];
  logic [DIGIT_IDX_W-1:0] idx;

  logic [PAD_W-1:0]       mag_next;
  logic [BCD_W-1:0]       bcd_next [MAX_DIGITS];
  logic [DIGIT_IDX_W-1:0] top_idx;

  assign value_in = value_bits[VALUE_WIDTH-1:0];
  assign neg      = is_signed & value_in[VALUE_WIDTH-1];
  assign mag_in   = neg ? (~value_in + VALUE_WIDTH'(1)) : value_in;

  // double dabble, STEP_BITS bits per cycle
  always_comb begin
    mag_next = mag;
    bcd_next = bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (bcd_next[i] >= BCD_W'(5)) begin
          bcd_next[i] = bcd_next[i] + BCD_W'(3);
        end
      end
      for (int i = MAX_DIGITS - 1; i > 0; i--) begin
        bcd_next[i] = {bcd_next[i][BCD_W-2:0], bcd_next[i-1][BCD_W-1]};
      end
      bcd_next[0] = {bcd_next[0][BCD_W-2:0], mag_next[PAD_W-1]};
      mag_next = {mag_next[PAD_W-2:0], 1'b0};
    end
  end

  // highest nonzero digit; zero value leaves index 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i] != '0) begin
        top_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= PAD_W'(mag_in);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        bcd[i] <= '0;
      end
    end else if (cmd.step) begin
      mag <= mag_next;
      bcd <= bcd_next;
    end
    if (cmd.count) begin
      idx <= top_idx;
    end else if (cmd.emit) begin
      idx <= idx - DIGIT_IDX_W'(1);
    end
    if (cmd.emit) begin
      digit_char <= ASCII_ZERO + CHAR_W'(bcd[idx]);
      last_digit <= (idx == '0);
    end
  end

  assign status.idx_zero = (idx == '0);

endmodule
`default_nettype wire

/* design/itod_ctrl.sv */
`default_nettype none
module itod_ctrl
  import itod_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire itod_status_t status,
  output itod_cmd_t         cmd
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    COUNT,
    EMIT
  } state_t;

  state_t                state;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load  = (state == IDLE) && in_valid;
    cmd.step  = (state == CONV);
    cmd.count = (state == COUNT);
    cmd.emit  = (state == EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            step_cnt <= '0;
            state    <= CONV;
          end
        end
        CONV: begin
          if (step_cnt == STEP_CNT_W'(STEPS - 1)) begin
            state <= COUNT;
          end else begin
            step_cnt <= step_cnt + STEP_CNT_W'(1);
          end
        end
        COUNT: begin
          state <= EMIT;
        end
        EMIT: begin
          if (out_free && status.idx_zero) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/integer_to_decimal_digits.sv */
`default_nettype none
// Binary to decimal ASCII converter. Each input word carries a 64-bit value and
// a signed flag; the block emits the decimal digits of the magnitude, most
// significant first, one output word per digit, with last_digit set on the
// final one. No sign character is produced; zero gives a single '0', and the
// most negative signed value converts exactly. The magnitude is turned into
// BCD by a shift-add-3 datapath taking four bits per cycle; then the top
// digit is located, and the digits are moved out one by one while the output
// side accepts. A new word is taken as soon as the last digit of the
// previous one has been moved into the output register, even if that digit
// is still waiting there.
module integer_to_decimal_digits
  import itod_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [63:0]       value_bits,
  input  wire logic              is_signed,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last_digit
);

  itod_cmd_t    cmd;
  itod_status_t status;

  // sequencing: idle -> convert -> locate top digit -> emit digits
  itod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // magnitude, BCD register, digit index and output payload register
  itod_datapath u_datapath (
    .clk        (clk),
    .value_bits (value_bits),
    .is_signed  (is_signed),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule
`default_nettype wire

/* tb/integer_to_decimal_digits_tb.sv */
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_digits_tb;
  import itod_pkg::*;

  // run length guard: far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // margin after the last expected digit, to catch any stray extra word
  localparam int DRAIN_CYCLES = 40;

  // one expected output word: a digit and its end-of-number marker
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_word_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [63:0]       value_bits;
  logic              is_signed;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  // digits still owed by the block, oldest first
  digit_word_t expected_digits[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  // random idling on the input side and stalls on the output side
  bit          send_gaps_on = 1'b1;
  bit          recv_stalls_on = 1'b1;
  int          stall_left = 0;

  integer_to_decimal_digits dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value_bits (value_bits),
    .is_signed  (is_signed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Decimal expansion of one input word. Only the low VALUE_WIDTH bits count;
  // a set sign bit under is_signed turns the value into its magnitude, which
  // for the most negative value is 2^(VALUE_WIDTH-1) and still fits unsigned.
  function automatic void expand_digits(input logic [63:0] raw, input logic signed_mode);
    logic [63:0] width_mask;
    logic [63:0] sign_mask;
    logic [63:0] magnitude;
    logic [3:0]  lsd_first[MAX_DIGITS];
    int          n_digits;
    digit_word_t w;
    width_mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
    sign_mask  = 64'd1 << (VALUE_WIDTH - 1);
    magnitude  = raw & width_mask;
    if (signed_mode && ((magnitude & sign_mask) != 64'd0))
      magnitude = (~magnitude + 64'd1) & width_mask;
    n_digits = 0;
    // at least one digit, so zero comes out as a single '0'
    do begin
      lsd_first[n_digits] = 4'(magnitude % 64'd10);
      magnitude = magnitude / 64'd10;
      n_digits++;
    end while (magnitude != 64'd0 && n_digits < MAX_DIGITS);
    for (int k = n_digits - 1; k >= 0; k--) begin
      w.ch   = CHAR_W'(lsd_first[k]) + ASCII_ZERO;
      w.last = (k == 0);
      expected_digits.push_back(w);
    end
  endfunction

  // Offer one word; an optional idle burst comes first, with junk on the
  // payload while valid is low. Returns right after the accepting edge.
  task automatic send_value(input logic [63:0] v, input logic s);
    int gap;
    begin
      gap = 0;
      if (send_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      @(negedge clk);
      if (gap > 0) begin
        in_valid   = 1'b0;
        value_bits = {$urandom, $urandom};
        is_signed  = 1'($urandom);
        repeat (gap) @(negedge clk);
      end
      in_valid   = 1'b1;
      value_bits = v;
      is_signed  = s;
      do @(posedge clk); while (!in_ready);
      expand_digits(v, s);
    end
  endtask

  // Random value with about n_digits decimal digits (20 means any 64 bits);
  // in signed mode half of them are negated to get small negatives too.
  function automatic logic [63:0] random_value(input int n_digits, input logic s);
    logic [63:0] limit;
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (n_digits < 20) begin
      limit = 64'd1;
      repeat (n_digits) limit = limit * 64'd10;
      v = v % limit;
    end
    if (s && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // zero in both modes and the first digit-count boundaries
  task automatic test_zero_and_small_values();
    begin
      send_value(64'd0, 1'b0);
      send_value(64'd0, 1'b1);
      send_value(64'd1, 1'b0);
      send_value(64'd9, 1'b0);
      send_value(64'd10, 1'b1);
      send_value(64'd999, 1'b0);
      send_value(64'd1000, 1'b1);
    end
  endtask

  // largest magnitudes: full 20 digits, the 19/20 digit boundary, sign bit
  task automatic test_width_extremes();
    begin
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_value(64'd9999999999999999999, 1'b0);
      send_value(64'd10000000000000000000, 1'b0);
      send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_value(64'h8000_0000_0000_0000, 1'b0);
      // most negative signed value: magnitude one past the largest positive
      send_value(64'h8000_0000_0000_0000, 1'b1);
    end
  endtask

  // two's complement negatives, magnitude only, no sign character expected
  task automatic test_signed_negatives();
    begin
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_value(-64'd10, 1'b1);
      send_value(-64'd12345, 1'b1);
      send_value(64'h8000_0000_0000_0001, 1'b1);
      send_value(-64'd1000000000000000000, 1'b1);
    end
  endtask

  // random digit counts and modes, with idling on both sides
  task automatic test_random_values(input int n_words);
    logic s;
    begin
      repeat (n_words) begin
        s = 1'($urandom);
        if ($urandom_range(0, 3) == 0) send_value({$urandom, $urandom}, s);
        else send_value(random_value($urandom_range(1, 20), s), s);
      end
    end
  endtask

  // same mix at full rate: no gaps on the input, no new stalls on the output
  task automatic test_back_to_back(input int n_words);
    begin
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      test_random_values(n_words);
    end
  endtask

  // output side: ready drops in random bursts
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // every accepted output word is compared with the oldest expected digit
  always @(posedge clk) begin
    digit_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected output word: digit_char %0d last_digit %0d",
               digit_char, last_digit);
        mismatch_count++;
      end else begin
        w = expected_digits.pop_front();
        if (digit_char !== w.ch) begin
          $error("digit_char: expected %0d, got %0d", w.ch, digit_char);
          mismatch_count++;
        end
        if (last_digit !== w.last) begin
          $error("last_digit: expected %0d, got %0d", w.last, last_digit);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    value_bits = 64'd0;
    is_signed  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_and_small_values();
    test_width_extremes();
    test_signed_negatives();
    test_random_values(91);
    test_back_to_back(40);

    @(negedge clk);
    in_valid = 1'b0;
    // drain: all digits out, then a margin for any stray extra word
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0) begin
      $error("%0d expected digits never arrived", expected_digits.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
